### rtl/sdrs_pkg.sv
`timescale 1ns / 1ps
// Package of the signed decimal radix sorter: cell commands, the control
// struct broadcast to the cell chain, and the controller state type.
// No dependencies.
package sdrs_pkg;

  localparam int unsigned ValueWidth = 32;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    cell_op_t                      op;
    logic signed [ValueWidth-1:0]  key;
  } cell_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

endpackage

### rtl/sdrs_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the sorter: the load channel and the
// sorted result channel. Depends on sdrs_pkg for the value width.
interface sdrs_load_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sdrs_pkg::ValueWidth-1:0] value;
  logic                                   last_in;

  modport source (output valid, value, last_in, input ready);
  modport sink   (input valid, value, last_in, output ready);
endinterface

interface sdrs_result_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sdrs_pkg::ValueWidth-1:0] sorted_value;
  logic                                   last_out;

  modport source (output valid, sorted_value, last_out, input ready);
  modport sink   (input valid, sorted_value, last_out, output ready);
endinterface

### rtl/sdrs_cell.sv
`timescale 1ns / 1ps
// One cell of the sorting chain: holds one value and its occupied flag.
// Depends on sdrs_pkg for the control struct and command codes.
module sdrs_cell (
  input  logic                                   clk,
  input  logic                                   rst,
  input  sdrs_pkg::cell_ctl_t                    ctl,
  input  logic                                   prev_ge,
  input  logic                                   prev_occ,
  input  logic signed [sdrs_pkg::ValueWidth-1:0] prev_value,
  input  logic                                   next_occ,
  input  logic signed [sdrs_pkg::ValueWidth-1:0] next_value,
  output logic                                   ge,
  output logic                                   occ,
  output logic signed [sdrs_pkg::ValueWidth-1:0] value
);

  logic                                   occ_next;
  logic signed [sdrs_pkg::ValueWidth-1:0] value_next;

  // An empty cell counts as greater, so the chain tail takes the key.
  assign ge = !occ || (value > ctl.key);

  always_comb begin
    occ_next   = occ;
    value_next = value;
    case (ctl.op)
      sdrs_pkg::CELL_INSERT: begin
        // The first greater cell takes the key; later ones move right.
        if (ge) begin
          value_next = prev_ge ? prev_value : ctl.key;
          occ_next   = occ | prev_occ;
        end
      end
      sdrs_pkg::CELL_SHIFT: begin
        value_next = next_value;
        occ_next   = next_occ;
      end
      default: begin
        occ_next   = occ;
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

### rtl/signed_decimal_radix_sorter.sv
`timescale 1ns / 1ps
// Top level of the signed sorter: controller plus a chain of sdrs_cell.
// Depends on sdrs_pkg, sdrs_ifs and sdrs_cell.
//
//   channel   direction  payload                   request moves
//   load      in         value, last_in            one value into the set
//   sorted    out        sorted_value, last_out    one value in ascending order
//
// Each load request inserts its value into the cell chain in place, every
// cell comparing it with its own value in parallel. After the request with
// last_in, the set leaves from the head cell at one result per cycle while
// sorted is ready.
// Values arriving while MAX_ITEMS cells are full are dropped.
// Reset is synchronous and clears the state and the occupied flags; no clearing pass.
// Load is held off during emission; a stall on sorted freezes the chain.
module signed_decimal_radix_sorter #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input logic clk,
  input logic rst,
  sdrs_load_if.sink     load,
  sdrs_result_if.source sorted
);

  sdrs_pkg::state_t    state, state_next;
  sdrs_pkg::cell_ctl_t ctl;

  logic [MAX_ITEMS-1:0]                   occ;
  logic [MAX_ITEMS-1:0]                   ge;
  logic signed [sdrs_pkg::ValueWidth-1:0] cell_value [MAX_ITEMS];

  logic load_fire;
  logic out_fire;
  logic full;

  assign full      = occ[MAX_ITEMS-1];
  assign load_fire = load.valid && load.ready;
  assign out_fire  = sorted.valid && sorted.ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sdrs_pkg::ST_LOAD: begin
        if (load_fire && load.last_in) begin
          state_next = sdrs_pkg::ST_EMIT;
        end
      end
      sdrs_pkg::ST_EMIT: begin
        if (out_fire && sorted.last_out) begin
          state_next = sdrs_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = sdrs_pkg::ST_LOAD;
      end
    endcase
  end

  // Outputs and cell commands.
  always_comb begin
    load.ready   = 1'b0;
    sorted.valid = 1'b0;
    ctl.op       = sdrs_pkg::CELL_HOLD;
    ctl.key      = load.value;
    case (state)
      sdrs_pkg::ST_LOAD: begin
        load.ready = 1'b1;
        if (load_fire && !full) begin
          ctl.op = sdrs_pkg::CELL_INSERT;
        end
      end
      sdrs_pkg::ST_EMIT: begin
        sorted.valid = 1'b1;
        if (out_fire) begin
          ctl.op = sdrs_pkg::CELL_SHIFT;
        end
      end
      default: begin
        load.ready   = 1'b0;
        sorted.valid = 1'b0;
      end
    endcase
  end

  assign sorted.sorted_value = cell_value[0];
  assign sorted.last_out     = !occ[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdrs_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                                   prev_ge;
    logic                                   prev_occ;
    logic signed [sdrs_pkg::ValueWidth-1:0] prev_value;
    logic                                   next_occ;
    logic signed [sdrs_pkg::ValueWidth-1:0] next_value;

    if (i == 0) begin : g_head
      // The head cell always has an occupied neighbor in front of it.
      assign prev_ge    = 1'b0;
      assign prev_occ   = 1'b1;
      assign prev_value = cell_value[0];
    end else begin : g_body
      assign prev_ge    = ge[i-1];
      assign prev_occ   = occ[i-1];
      assign prev_value = cell_value[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_occ   = 1'b0;
      assign next_value = cell_value[i];
    end else begin : g_inner
      assign next_occ   = occ[i+1];
      assign next_value = cell_value[i+1];
    end

    sdrs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_ge    (prev_ge),
      .prev_occ   (prev_occ),
      .prev_value (prev_value),
      .next_occ   (next_occ),
      .next_value (next_value),
      .ge         (ge[i]),
      .occ        (occ[i]),
      .value      (cell_value[i])
    );
  end

  // The occupied cells always form a prefix of the chain.
  a_occ_prefix: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, occ} + {{MAX_ITEMS{1'b0}}, 1'b1}))
    else $error("occupied cells are not a contiguous prefix");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == sdrs_pkg::ST_EMIT |-> occ[0])
    else $error("emitting from an empty chain");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    occ[1] |-> cell_value[0] <= cell_value[1])
    else $error("head cells out of order");

  a_empty_after_last: assert property (@(posedge clk) disable iff (rst)
    out_fire && sorted.last_out |=> occ == '0)
    else $error("chain not empty after the final result");

endmodule
